// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational property sampled on every clock edge.
`define AST_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define AST_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/lpd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpd_pkg
// Types and constants shared by the length-prefixed packet deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

	typedef logic [2:0] hdr_cnt_t;

	localparam hdr_cnt_t ID_BYTES      = 3'd2;
	localparam hdr_cnt_t HDR_BYTES     = 3'd6;
	localparam hdr_cnt_t PAYLOAD_PHASE = 3'd6;
	localparam hdr_cnt_t CNT_START     = 3'd0;

	typedef struct packed {
		logic [15:0] packet_id;
		logic [7:0]  payload_byte;
		logic        last_of_packet;
		logic        empty_packet;
	} lpd_res_t;

endpackage

// ===== rtl/lpd_in_reg.sv =====
// ----------------------------------------------------------------------------
// lpd_in_reg
// Input register stage: holds one received byte until the core consumes it.
// ----------------------------------------------------------------------------
module lpd_in_reg import lpd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	input  logic [7:0] rx_byte,
	output logic       rx_stall,
	input  logic       adv_s1,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	logic take;

	assign rx_stall = valid_s1 && !adv_s1;
	assign take     = rx_valid && !rx_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv_s1) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

// ===== rtl/lpd_core.sv =====
// ----------------------------------------------------------------------------
// lpd_core
// Header collection, length countdown and result formation for one byte.
// ----------------------------------------------------------------------------
module lpd_core import lpd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid_s1,
	input  logic [7:0] byte_s1,
	input  logic       out_free,
	output logic       adv_s1,
	output logic       load,
	output lpd_res_t   res
);

	hdr_cnt_t    cnt_q, cnt, cnt_inc, cnt_next;
	logic [15:0] id_q, id_next;
	logic [31:0] rem_q, rem_next, rem_dec;
	logic        emit, last, is_empty;

	always_comb begin
		cnt      = (cnt_q > PAYLOAD_PHASE) ? CNT_START : cnt_q;
		cnt_inc  = cnt + 3'd1;
		rem_dec  = rem_q - 32'd1;
		id_next  = id_q;
		rem_next = rem_q;
		cnt_next = cnt_inc;
		emit     = 1'b0;
		last     = 1'b0;
		is_empty = 1'b0;
		if (cnt_q == PAYLOAD_PHASE) begin
			rem_next = rem_dec;
			emit     = 1'b1;
			last     = (rem_dec == 32'd0);
			cnt_next = last ? CNT_START : PAYLOAD_PHASE;
		end else begin
			if (cnt < ID_BYTES) begin
				id_next = (cnt == CNT_START) ? {8'd0, byte_s1} : {id_q[7:0], byte_s1};
			end else begin
				rem_next = (cnt == ID_BYTES) ? {24'd0, byte_s1} : {rem_q[23:0], byte_s1};
			end
			if (cnt_inc == HDR_BYTES) begin
				if (rem_next == 32'd0) begin
					emit     = 1'b1;
					last     = 1'b1;
					is_empty = 1'b1;
					cnt_next = CNT_START;
				end else begin
					cnt_next = PAYLOAD_PHASE;
				end
			end
		end
	end

	assign adv_s1 = valid_s1 && (!emit || out_free);
	assign load   = adv_s1 && emit;

	assign res.packet_id      = id_q;
	assign res.payload_byte   = is_empty ? 8'd0 : byte_s1;
	assign res.last_of_packet = last;
	assign res.empty_packet   = is_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CNT_START;
			id_q  <= 16'd0;
			rem_q <= 32'd0;
		end else if (adv_s1) begin
			cnt_q <= cnt_next;
			id_q  <= id_next;
			rem_q <= rem_next;
		end
	end

endmodule

// ===== rtl/lpd_out_reg.sv =====
// ----------------------------------------------------------------------------
// lpd_out_reg
// Result register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module lpd_out_reg import lpd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     load,
	input  lpd_res_t res,
	input  logic     pkt_stall,
	output logic     out_free,
	output logic     pkt_valid,
	output lpd_res_t res_q
);

	assign out_free = !pkt_valid || !pkt_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_valid <= 1'b0;
		end else if (out_free) begin
			pkt_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

// ===== rtl/length_prefixed_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer
// Splits a byte stream of [id:2][length:4][payload] packets into tagged bytes.
// ----------------------------------------------------------------------------
// Accepts one byte per clock while rx_stall is low and emits one result per
// payload byte, tagged with the 16-bit packet id, with last_of_packet on the
// final byte. A header with zero length gives a single result with
// empty_packet and last_of_packet set; other header bytes produce no result.
// Each accepted byte lands in the input register, and one pass of
// header/count logic feeds the result register, which loads only when free.
// Sustained rate is one byte per cycle while rx_stall is low; backpressure on
// pkt_stall holds the result register and reaches rx_stall only when a
// result-producing byte is waiting.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer import lpd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	output logic        pkt_valid,
	input  logic        pkt_stall,
	output logic [15:0] packet_id,
	output logic [7:0]  payload_byte,
	output logic        last_of_packet,
	output logic        empty_packet
);

	logic       valid_s1, adv_s1, load, out_free;
	logic [7:0] byte_s1;
	lpd_res_t   res, res_q;

	lpd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_byte  (rx_byte),
		.rx_stall (rx_stall),
		.adv_s1   (adv_s1),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	lpd_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.out_free (out_free),
		.adv_s1   (adv_s1),
		.load     (load),
		.res      (res)
	);

	lpd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.res       (res),
		.pkt_stall (pkt_stall),
		.out_free  (out_free),
		.pkt_valid (pkt_valid),
		.res_q     (res_q)
	);

	assign packet_id      = res_q.packet_id;
	assign payload_byte   = res_q.payload_byte;
	assign last_of_packet = res_q.last_of_packet;
	assign empty_packet   = res_q.empty_packet;

endmodule

// ===== rtl/lpd_checker.sv =====
// ----------------------------------------------------------------------------
// lpd_checker
// Port-level assertions for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpd_checker import lpd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        rx_valid,
	input logic        rx_stall,
	input logic [7:0]  rx_byte,
	input logic        pkt_valid,
	input logic        pkt_stall,
	input logic [15:0] packet_id,
	input logic [7:0]  payload_byte,
	input logic        last_of_packet,
	input logic        empty_packet
);

	logic pkt_take;

	assign pkt_take = pkt_valid && !pkt_stall;

	`AST_NEXT(a_rx_hold, rx_valid && rx_stall, rx_valid && $stable(rx_byte), "stalled input changed")
	`AST_NEXT(a_pkt_hold, pkt_valid && pkt_stall, pkt_valid, "stalled result dropped")
	`AST_ALWAYS(a_empty_last, !pkt_valid || !empty_packet || last_of_packet, "empty not last")
	`AST_ALWAYS(a_empty_zero, !pkt_valid || !empty_packet || payload_byte == 8'd0, "empty data nonzero")
	`AST_NEXT(a_same_id, pkt_take && !last_of_packet,
		!pkt_valid || packet_id == $past(packet_id), "id changed inside a packet")

endmodule

bind length_prefixed_packet_deframer lpd_checker u_lpd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rx_valid       (rx_valid),
	.rx_stall       (rx_stall),
	.rx_byte        (rx_byte),
	.pkt_valid      (pkt_valid),
	.pkt_stall      (pkt_stall),
	.packet_id      (packet_id),
	.payload_byte   (payload_byte),
	.last_of_packet (last_of_packet),
	.empty_packet   (empty_packet)
);
